[rtl/bed_pkg.sv]
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants for the backslash escape decoder
// Decode modes, character codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package bed_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT   = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_OCT    = 2'd2,
    MODE_HEX    = 2'd3
  } bed_mode_t;

  localparam logic [7:0]  CH_BSL   = 8'h5C;  // backslash
  localparam logic [7:0]  CH_ESC   = 8'h1B;  // result of \e
  localparam logic [7:0]  CH_VT    = 8'h0B;  // result of \v
  localparam logic [11:0] BYTE_MAX = 12'h0FF;

  // Output queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Results caused by one input item: zero, one or two bytes
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] data0;
    logic [7:0] data1;
    logic       last;
  } bed_res_t;

  // One entry of the output queue
  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       string_end;
  } bed_entry_t;

endpackage

[rtl/backslash_escape_decoder_unit.sv]
// ----------------------------------------------------------------------------
// backslash_escape_decoder_unit: C-style escape sequence decoder
// Decodes a byte stream, one character per transfer, into result bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one character per transfer, with
//   in_last on the final character of a string.
//   Result channel (out_valid/out_ready): decoded bytes; out_run_last marks
//   the last result of one input character, out_string_end the last result
//   of the string. A character gives zero, one or two results.
//   Config: cfg_we/cfg_data set the escape enable bit; write it only while
//   the block is idle. With the bit clear every byte passes through.
// Dataflow and throughput:
//   A character waits in the input register, and the decode logic writes
//   its results into the result queue, from where they are handed out.
//   One character per cycle is taken as long as the output side keeps up;
//   the single result port (one transfer per cycle) sets that figure, so a
//   character with two results needs a second output transfer.
// Reset and stall:
//   Reset empties the input register and result queue, clears the enable
//   bit and returns the decoder to text mode. When the receiver stalls the
//   4-entry queue fills, the decoder holds, and in_ready drops once the
//   input register is occupied.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_unit import bed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);

  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_last;
  logic       room;
  logic       adv;
  bed_res_t   res;

  // Advance the held character once the queue can take two results
  assign adv = stg_valid && room;

  bed_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .adv       (adv),
    .stg_valid (stg_valid),
    .stg_byte  (stg_byte),
    .stg_last  (stg_last)
  );

  // Decode state moves only when the character leaves the input register
  bed_decoder u_decoder (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .c        (stg_byte),
    .last     (stg_last),
    .adv      (adv),
    .res      (res)
  );

  bed_out_queue u_out_queue (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (adv),
    .res            (res),
    .room           (room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule

[rtl/bed_in_stage.sv]
// ----------------------------------------------------------------------------
// bed_in_stage: input register
// Holds one accepted character until the decoder can hand on its results.
// ----------------------------------------------------------------------------
module bed_in_stage import bed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       adv,
  output logic       stg_valid,
  output logic [7:0] stg_byte,
  output logic       stg_last
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load;

  assign in_ready = !valid_r || adv;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign stg_valid = valid_r;
  assign stg_byte  = byte_r;
  assign stg_last  = last_r;

endmodule

[rtl/bed_decoder.sv]
// ----------------------------------------------------------------------------
// bed_decoder: escape decode logic and decode state
// Maps one character and the current mode to up to two result bytes.
// ----------------------------------------------------------------------------
module bed_decoder import bed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_data,
  input  logic [7:0] c,
  input  logic       last,
  input  logic       adv,
  output bed_res_t   res
);

  logic       en_r;
  bed_mode_t  mode_r, mode_nxt;
  logic [7:0] val_r, val_nxt;
  logic [1:0] dl_r, dl_nxt;
  logic       is_dig;
  logic [3:0] dig;
  logic [11:0] nv;
  logic [1:0] cnt;
  logic [7:0] r0, r1;

  always_comb begin
    cnt      = 2'd0;
    r0       = 8'h00;
    r1       = 8'h00;
    mode_nxt = mode_r;
    val_nxt  = val_r;
    dl_nxt   = dl_r;
    is_dig   = 1'b0;
    dig      = 4'h0;
    nv       = 12'h000;

    if (!en_r) begin
      mode_nxt = MODE_TEXT;
      val_nxt  = 8'h00;
      dl_nxt   = 2'd0;
      r0       = c;
      cnt      = 2'd1;
    end else begin
      case (mode_r)
        MODE_TEXT: begin
          if (c == CH_BSL) begin
            mode_nxt = MODE_BSLASH;
          end else begin
            r0  = c;
            cnt = 2'd1;
          end
        end
        MODE_BSLASH: begin
          mode_nxt = MODE_TEXT;
          cnt      = 2'd1;
          case (c)
            CH_BSL: r0 = CH_BSL;
            8'h61:  r0 = 8'h07;   // a
            8'h62:  r0 = 8'h08;   // b
            8'h65:  r0 = CH_ESC;  // e
            8'h66:  r0 = 8'h0C;   // f
            8'h6E:  r0 = 8'h0A;   // n
            8'h72:  r0 = 8'h0D;   // r
            8'h74:  r0 = 8'h09;   // t
            8'h76:  r0 = CH_VT;   // v
            8'h30: begin          // 0: up to three more octal digits
              mode_nxt = MODE_OCT;
              val_nxt  = 8'h00;
              dl_nxt   = 2'd3;
              cnt      = 2'd0;
            end
            8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37: begin
              mode_nxt = MODE_OCT;
              val_nxt  = {5'b0, c[2:0]};
              dl_nxt   = 2'd2;
              cnt      = 2'd0;
            end
            8'h78: begin          // x
              mode_nxt = MODE_HEX;
              val_nxt  = 8'h00;
              dl_nxt   = 2'd2;
              cnt      = 2'd0;
            end
            default: r0 = c;      // unknown escape: drop the backslash
          endcase
        end
        default: begin
          if (mode_r == MODE_OCT) begin
            is_dig = c inside {[8'h30:8'h37]};
            dig    = {1'b0, c[2:0]};
            nv     = {1'b0, val_r, 3'b000} + {8'h00, dig};
          end else begin
            if (c inside {[8'h30:8'h39]}) begin
              is_dig = 1'b1;
              dig    = c[3:0];
            end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
              is_dig = 1'b1;
              dig    = c[3:0] + 4'd9;
            end
            nv = {val_r, 4'h0} + {8'h00, dig};
          end

          if (!is_dig || dl_r == 2'd0) begin
            // non-digit ends the escape, then counts as text
            r0       = val_r;
            cnt      = 2'd1;
            mode_nxt = MODE_TEXT;
            if (c == CH_BSL) begin
              mode_nxt = MODE_BSLASH;
            end else begin
              r1  = c;
              cnt = 2'd2;
            end
          end else if (nv > BYTE_MAX) begin
            // overflow: value, then the digit as a literal
            r0       = val_r;
            r1       = c;
            cnt      = 2'd2;
            mode_nxt = MODE_TEXT;
          end else begin
            val_nxt = nv[7:0];
            dl_nxt  = dl_r - 2'd1;
            if (dl_nxt == 2'd0) begin
              r0       = nv[7:0];
              cnt      = 2'd1;
              mode_nxt = MODE_TEXT;
            end
          end
        end
      endcase
    end

    // Flush any pending escape at the end of the string
    if (last) begin
      if (mode_nxt == MODE_BSLASH) begin
        if (cnt == 2'd0) r0 = CH_BSL;
        else r1 = CH_BSL;
        cnt = cnt + 2'd1;
      end else if (mode_nxt == MODE_OCT || mode_nxt == MODE_HEX) begin
        if (cnt == 2'd0) r0 = val_nxt;
        else r1 = val_nxt;
        cnt = cnt + 2'd1;
      end
      mode_nxt = MODE_TEXT;
      val_nxt  = 8'h00;
      dl_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      mode_r <= MODE_TEXT;
      val_r  <= 8'h00;
      dl_r   <= 2'd0;
    end else begin
      if (cfg_we) begin
        en_r <= cfg_data;
      end
      if (adv) begin
        mode_r <= mode_nxt;
        val_r  <= val_nxt;
        dl_r   <= dl_nxt;
      end
    end
  end

  assign res.cnt   = cnt;
  assign res.data0 = r0;
  assign res.data1 = r1;
  assign res.last  = last;

endmodule

[rtl/bed_out_queue.sv]
// ----------------------------------------------------------------------------
// bed_out_queue: result register queue
// Takes up to two results per cycle and hands out one per transfer.
// ----------------------------------------------------------------------------
module bed_out_queue import bed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bed_res_t   res,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_string_end
);

  bed_entry_t              mem [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]       cnt_r, cnt_nxt;
  logic [1:0]              push_n;
  logic                    pop;
  logic [QPTR_W-1:0]       wr_ptr_p1;
  bed_entry_t              e0, e1;

  assign room      = cnt_r <= QCNT_W'(QDEPTH - 2);
  assign pop       = out_valid && out_ready;
  assign push_n    = push ? res.cnt : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  assign e0.data       = res.data0;
  assign e0.run_last   = (res.cnt == 2'd1);
  assign e0.string_end = (res.cnt == 2'd1) && res.last;
  assign e1.data       = res.data1;
  assign e1.run_last   = 1'b1;
  assign e1.string_end = res.last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr_r] <= e0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr_p1] <= e1;
    end
  end

  assign out_valid      = cnt_r != '0;
  assign out_byte       = mem[rd_ptr_r].data;
  assign out_run_last   = mem[rd_ptr_r].run_last;
  assign out_string_end = mem[rd_ptr_r].string_end;

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for backslash_escape_decoder_unit
// Feeds strings through the input channel with random gaps and result-side
// stalls, predicts every decoded byte and its markers, and checks each
// result transfer in order against the predicted stream.
// ----------------------------------------------------------------------------
module tb_top;
  import bed_pkg::*;

  // Control characters produced by the single-letter escapes
  localparam logic [7:0] CH_BEL = 8'h07;  // \a
  localparam logic [7:0] CH_BS  = 8'h08;  // \b
  localparam logic [7:0] CH_TAB = 8'h09;  // \t
  localparam logic [7:0] CH_LF  = 8'h0A;  // \n
  localparam logic [7:0] CH_FF  = 8'h0C;  // \f
  localparam logic [7:0] CH_CR  = 8'h0D;  // \r

  localparam int SETTLE_CYCLES  = 6;     // pipeline is 2 deep; leave margin
  localparam int HOLD_CYCLES    = 64;    // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer at all
  localparam int RAND_PHASES    = 13;
  localparam int PHASE_ITEMS    = 108;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic       out_run_last;
  logic       out_string_end;

  // Predicted decoder state and register copy
  logic       esc_on;
  bed_mode_t  dec_mode;
  logic [7:0] num_val;
  logic [1:0] digits_left;

  bed_entry_t decoded_q[$];   // decoded bytes still to come out of the block
  logic [7:0] str_q[$];       // characters of the string being built

  bit         in_idle_on;
  bit         out_idle_on;
  bit         hold_req;
  int         mismatch_cnt;
  int         quiet_cycles;
  int         sent_cnt;
  bed_entry_t want;

  backslash_escape_decoder_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Decode one accepted character and queue the bytes it releases.
  // --------------------------------------------------------------------------
  function automatic void decode_char(input logic [7:0] c, input logic last);
    logic [7:0] got[$];
    int         d;
    int         radix;
    int         nv;
    bed_entry_t e;
    if (!esc_on) begin
      // Pass-through also throws away any escape left pending
      dec_mode    = MODE_TEXT;
      num_val     = '0;
      digits_left = '0;
      got.push_back(c);
    end else begin
      case (dec_mode)
        MODE_TEXT: begin
          if (c == CH_BSL) dec_mode = MODE_BSLASH;
          else got.push_back(c);
        end
        MODE_BSLASH: begin
          dec_mode = MODE_TEXT;
          case (c)
            CH_BSL: got.push_back(CH_BSL);
            "a":    got.push_back(CH_BEL);
            "b":    got.push_back(CH_BS);
            "e":    got.push_back(CH_ESC);
            "f":    got.push_back(CH_FF);
            "n":    got.push_back(CH_LF);
            "r":    got.push_back(CH_CR);
            "t":    got.push_back(CH_TAB);
            "v":    got.push_back(CH_VT);
            "0": begin
              dec_mode    = MODE_OCT;
              num_val     = '0;
              digits_left = 2'd3;
            end
            "1", "2", "3", "4", "5", "6", "7": begin
              // the leading digit counts toward the three
              dec_mode    = MODE_OCT;
              num_val     = c - "0";
              digits_left = 2'd2;
            end
            "x": begin
              dec_mode    = MODE_HEX;
              num_val     = '0;
              digits_left = 2'd2;
            end
            default: got.push_back(c);  // unknown escape: drop the backslash
          endcase
        end
        default: begin
          if (dec_mode == MODE_OCT) begin
            radix = 8;
            d     = (c >= "0" && c <= "7") ? c - "0" : -1;
          end else begin
            radix = 16;
            if (c >= "0" && c <= "9")      d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            else                           d = -1;
          end
          if (d < 0 || digits_left == 0) begin
            // non-digit closes the escape, then counts as plain text
            got.push_back(num_val);
            dec_mode = MODE_TEXT;
            if (c == CH_BSL) dec_mode = MODE_BSLASH;
            else got.push_back(c);
          end else begin
            nv = int'(num_val) * radix + d;
            if (nv > int'(BYTE_MAX)) begin
              // overflow: value so far, then the digit as a literal
              got.push_back(num_val);
              got.push_back(c);
              dec_mode = MODE_TEXT;
            end else begin
              num_val     = nv[7:0];
              digits_left = digits_left - 2'd1;
              if (digits_left == 0) begin
                got.push_back(num_val);
                dec_mode = MODE_TEXT;
              end
            end
          end
        end
      endcase
    end

    if (last) begin
      // flush whatever the string leaves open
      if (dec_mode == MODE_BSLASH) got.push_back(CH_BSL);
      else if (dec_mode == MODE_OCT || dec_mode == MODE_HEX) got.push_back(num_val);
      dec_mode    = MODE_TEXT;
      num_val     = '0;
      digits_left = '0;
    end

    for (int k = 0; k < got.size(); k++) begin
      e.data       = got[k];
      e.run_last   = (k == got.size() - 1);
      e.string_end = e.run_last && last;
      decoded_q.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatch_cnt++;
    $display("mismatch: %s got 0x%0h want 0x%0h at %0t", what, got_v, want_v, $time);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: compare every result transfer with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result, byte", out_byte, 0);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", out_byte, want.data);
        if (out_run_last !== want.run_last)
          report_mismatch("out_run_last", out_run_last, want.run_last);
        if (out_string_end !== want.string_end)
          report_mismatch("out_string_end", out_string_end, want.string_end);
      end
    end
  end

  // Watchdog: a long stretch without any transfer means the block hung
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("** backslash_escape_decoder_unit: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: draw a stall before each result transfer; a pending hold
  // request turns that stall into one long hold-off counted here.
  // --------------------------------------------------------------------------
  initial begin
    int n;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        n        = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = out_idle_on ? $urandom_range(0, 7) : 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one character, hold it until the transfer, then predict it
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= c;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    decode_char(c, last);
    sent_cnt++;
  endtask

  // Send the built string; mark the final character when the string ends
  task automatic send_run(input bit ends);
    for (int i = 0; i < str_q.size(); i++)
      send_char(str_q[i], ends && (i == str_q.size() - 1));
    str_q.delete();
  endtask

  task automatic send_text(input string s, input bit ends);
    for (int i = 0; i < s.len(); i++)
      str_q.push_back(s[i]);
    send_run(ends);
  endtask

  // Drop valid, wait for all predicted results, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_escapes(input logic v);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    esc_on    = v;
  endtask

  // --------------------------------------------------------------------------
  // Random string content
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10)      return 8'("0" + r);
    else if (r < 16) return 8'("a" + r - 10);
    else             return 8'("A" + r - 16);
  endfunction

  // Append one token: mostly well-formed escapes, some plain text and noise
  function automatic void append_token();
    string      letters;
    logic [7:0] b;
    int         r;
    int         k;
    letters = "\\abefnrtv";
    r = $urandom_range(0, 99);
    if (r < 30) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_BSL);
      str_q.push_back(b);
    end else if (r < 45) begin
      str_q.push_back(CH_BSL);
      str_q.push_back(letters[$urandom_range(0, letters.len() - 1)]);
    end else if (r < 62) begin
      // octal: \0 or \1..\7, then up to four digits to run past the limit
      str_q.push_back(CH_BSL);
      str_q.push_back(8'("0" + $urandom_range(0, 7)));
      k = $urandom_range(0, 4);
      repeat (k) str_q.push_back(8'("0" + $urandom_range(0, 7)));
      if ($urandom_range(0, 5) == 0) str_q.push_back(8'("8" + $urandom_range(0, 1)));
    end else if (r < 78) begin
      str_q.push_back(CH_BSL);
      str_q.push_back("x");
      k = $urandom_range(0, 3);
      repeat (k) str_q.push_back(rand_hex_char());
    end else if (r < 88) begin
      // backslash before anything at all
      str_q.push_back(CH_BSL);
      str_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      str_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_passthrough();
    // escapes are off after reset; a backslash is just a byte
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_BSL, 1'b1);
  endtask

  task automatic test_letter_escapes();
    set_escapes(1'b1);
    send_text("\\\\\\e\\v", 1'b1);
    send_text("\\q", 1'b1);        // unknown escape keeps only the letter
    send_text("\\", 1'b1);         // trailing backslash
  endtask

  task automatic test_numeric_escapes();
    send_text("\\400", 1'b1);      // third digit overflows the byte
    send_text("\\x41", 1'b1);      // digit limit reached
    send_text("\\x4g", 1'b1);      // non-digit closes the escape
    send_text("\\7", 1'b1);        // escape still open at end of string
  endtask

  task automatic test_disable_midstring();
    send_text("\\x", 1'b0);
    set_escapes(1'b0);
    send_text("A", 1'b1);          // pending escape is discarded
    set_escapes(1'b1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    in_idle_on = 1'b0;
    hold_req   = 1'b1;
    // keep offering while the receiver holds off, so the input stalls
    repeat (30) append_token();
    send_run(1'b1);
    wait_idle();
  endtask

  task automatic test_random();
    int target;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_escapes((ph % 5 == 3) ? 1'b0 : 1'b1);
      in_idle_on  = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      out_idle_on = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      target = sent_cnt + PHASE_ITEMS;
      while (sent_cnt < target) begin
        repeat ($urandom_range(1, 8)) append_token();
        if ($urandom_range(0, 9) == 0) str_q.push_back(CH_BSL);
        send_run(1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    in_byte  <= '0;
    in_last  <= 1'b0;
    esc_on       = 1'b0;
    dec_mode     = MODE_TEXT;
    num_val      = '0;
    digits_left  = '0;
    in_idle_on   = 1'b1;
    out_idle_on  = 1'b1;
    hold_req     = 1'b0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    sent_cnt     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_letter_escapes();
    test_numeric_escapes();
    test_disable_midstring();
    test_backpressure();
    test_random();

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("** backslash_escape_decoder_unit: PASSED **");
    end else begin
      $display("** backslash_escape_decoder_unit: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bed_pkg.sv
rtl/bed_in_stage.sv
rtl/bed_decoder.sv
rtl/bed_out_queue.sv
rtl/backslash_escape_decoder_unit.sv
tb/tb_top.sv
